/* rtl/byoclk_pkg.sv */
// ----------------------------------------------------------------------------
// byoclk_pkg
// Shared types and constants of the byo-yomi game clock: setting limits,
// item kinds, register offsets and the structs passed between the stages.
// ----------------------------------------------------------------------------
package byoclk_pkg;

    // largest time setting in seconds (248 days)
    localparam int unsigned MAX_SEC    = 248 * 24 * 60 * 60;
    localparam int unsigned CS_PER_SEC = 100;
    localparam int unsigned MS_PER_CS  = 10;

    localparam int SEC_W   = 25;
    localparam int CS_W    = 31;
    localparam int BYO_W   = 32;
    localparam int CNT_W   = 8;
    localparam int MS_W    = 32;
    localparam int QCS_W   = 29;

    localparam logic [SEC_W-1:0] MAX_SEC_V = SEC_W'(MAX_SEC);

    // floor(x / 10) = (x * RECIP) >> SHIFT for every 32-bit x
    localparam logic [MS_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int              DIV10_SHIFT = 35;

    // overrun floor of the overtime counter
    localparam logic signed [BYO_W-1:0] BYO_MIN = -32'sd429496729;

    // item kinds
    typedef enum logic [1:0] {
        KIND_MOVE     = 2'd0,
        KIND_SET_LEFT = 2'd1,
        KIND_RESET    = 2'd2
    } kind_t;

    // register offsets (word index)
    localparam logic [1:0] REG_MAIN_TIME    = 2'd0;
    localparam logic [1:0] REG_BYO_TIME     = 2'd1;
    localparam logic [1:0] REG_STONE_COUNT  = 2'd2;
    localparam logic [1:0] REG_PERIOD_COUNT = 2'd3;

    // effective settings and refill strobe from the register block
    typedef struct packed {
        logic [CS_W-1:0]  main_cs;
        logic [CS_W-1:0]  byo_cs;
        logic [CNT_W-1:0] stones;
        logic [CNT_W-1:0] periods;
        logic             infinite;
        logic             refill;
    } eff_cfg_t;

    // item after the millisecond-to-centisecond stage
    typedef struct packed {
        logic [1:0]       kind;
        logic             player;
        logic [QCS_W-1:0] rem_cs;
        logic [SEC_W-1:0] time_left_sec;
        logic [CNT_W-1:0] count_left;
    } stage_t;

    // reported clock of one player
    typedef struct packed {
        logic                    side;
        logic [CS_W-1:0]         main_left_cs;
        logic signed [BYO_W-1:0] byo_left_cs;
        logic [CNT_W-1:0]        periods_remaining;
        logic [CNT_W-1:0]        stones_remaining;
        logic                    in_overtime;
        logic                    time_over;
        logic                    infinite_time;
    } report_t;

endpackage

/* rtl/byoclk_item_if.sv */
// ----------------------------------------------------------------------------
// byoclk_item_if
// Valid/ready channel carrying one clock event into the block.
// ----------------------------------------------------------------------------
interface byoclk_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        player;
    logic [31:0] elapsed_ms;
    logic [24:0] time_left_sec;
    logic [7:0]  count_left;

    modport source (output valid, kind, player, elapsed_ms, time_left_sec, count_left,
                    input ready);
    modport sink   (input valid, kind, player, elapsed_ms, time_left_sec, count_left,
                    output ready);
endinterface

/* rtl/byoclk_result_if.sv */
// ----------------------------------------------------------------------------
// byoclk_result_if
// Valid/ready channel carrying one player's clock report out of the block.
// ----------------------------------------------------------------------------
interface byoclk_result_if;
    logic               valid;
    logic               ready;
    logic               side;
    logic [30:0]        main_left_cs;
    logic signed [31:0] byo_left_cs;
    logic [7:0]         periods_remaining;
    logic [7:0]         stones_remaining;
    logic               in_overtime;
    logic               time_over;
    logic               infinite_time;

    modport source (output valid, side, main_left_cs, byo_left_cs, periods_remaining,
                    stones_remaining, in_overtime, time_over, infinite_time,
                    input ready);
    modport sink   (input valid, side, main_left_cs, byo_left_cs, periods_remaining,
                    stones_remaining, in_overtime, time_over, infinite_time,
                    output ready);
endinterface

/* rtl/byoclk_cfg.sv */
// ----------------------------------------------------------------------------
// byoclk_cfg
// APB register block for the time settings. Normalizes them into the
// effective settings and pulses a refill of both clocks after each write.
// ----------------------------------------------------------------------------
module byoclk_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output byoclk_pkg::eff_cfg_t eff
);
    import byoclk_pkg::*;

    logic [SEC_W-1:0] main_time_sec_reg;
    logic [SEC_W-1:0] byo_time_sec_reg;
    logic [CNT_W-1:0] byo_stone_count_reg;
    logic [CNT_W-1:0] byo_period_count_reg;
    logic             refill_reg;

    logic             wr_en;
    logic [1:0]       reg_idx;
    logic             over_limit;
    logic             pair_bad;
    logic [CS_W-1:0]  main_cs;
    logic [CS_W-1:0]  byo_cs;
    logic [CNT_W-1:0] periods_e;
    logic [CNT_W-1:0] stones_e;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes, refill strobe in the cycle after the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_time_sec_reg    <= '0;
            byo_time_sec_reg     <= '0;
            byo_stone_count_reg  <= '0;
            byo_period_count_reg <= '0;
            refill_reg           <= 1'b0;
        end
        else
        begin
            refill_reg <= wr_en;
            if (wr_en)
            begin
                case (reg_idx)
                    REG_MAIN_TIME:    main_time_sec_reg    <= pwdata[SEC_W-1:0];
                    REG_BYO_TIME:     byo_time_sec_reg     <= pwdata[SEC_W-1:0];
                    REG_STONE_COUNT:  byo_stone_count_reg  <= pwdata[CNT_W-1:0];
                    REG_PERIOD_COUNT: byo_period_count_reg <= pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_MAIN_TIME:    prdata = 32'(main_time_sec_reg);
            REG_BYO_TIME:     prdata = 32'(byo_time_sec_reg);
            REG_STONE_COUNT:  prdata = 32'(byo_stone_count_reg);
            REG_PERIOD_COUNT: prdata = 32'(byo_period_count_reg);
            default:          prdata = '0;
        endcase
    end

    // normalize settings
    always_comb
    begin
        over_limit = (main_time_sec_reg > MAX_SEC_V) || (byo_time_sec_reg > MAX_SEC_V);
        pair_bad   = (byo_stone_count_reg == '0) == (byo_period_count_reg == '0);
        main_cs    = CS_W'(main_time_sec_reg) * CS_W'(CS_PER_SEC);
        byo_cs     = CS_W'(byo_time_sec_reg) * CS_W'(CS_PER_SEC);
        periods_e  = byo_period_count_reg;
        stones_e   = byo_stone_count_reg;
        if (over_limit)
        begin
            main_cs   = '0;
            byo_cs    = '0;
            periods_e = '0;
            stones_e  = '0;
        end
        else
        begin
            if (pair_bad)
            begin
                byo_cs    = '0;
                periods_e = '0;
            end
            if (byo_cs == '0 && periods_e == '0)
            begin
                stones_e = '0;
            end
        end
    end

    assign eff.main_cs  = main_cs;
    assign eff.byo_cs   = byo_cs;
    assign eff.stones   = stones_e;
    assign eff.periods  = periods_e;
    assign eff.infinite = (main_cs == '0) && (byo_cs == '0) && (stones_e == '0)
                          && (periods_e == '0);
    assign eff.refill   = refill_reg;

endmodule

/* rtl/byoclk_div10.sv */
// ----------------------------------------------------------------------------
// byoclk_div10
// Input stage: registers the accepted item with its elapsed time already
// converted from milliseconds to centiseconds by a reciprocal multiply.
// ----------------------------------------------------------------------------
module byoclk_div10 (
    input  logic                clk,
    input  logic                rst_n,
    byoclk_item_if.sink         item,
    input  logic                advance,
    output logic                stg_valid,
    output byoclk_pkg::stage_t  stg
);
    import byoclk_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    stage_t              stg_reg;
    stage_t              stg_next;
    logic [2*MS_W-1:0]   prod;
    logic                load;

    // stage is free when empty or when it moves on this cycle
    assign item.ready = !valid_reg || advance;
    assign load       = item.valid && item.ready;

    // floor(ms / 10)
    assign prod = {{MS_W{1'b0}}, item.elapsed_ms} * {{MS_W{1'b0}}, DIV10_RECIP};

    always_comb
    begin
        stg_next               = stg_reg;
        stg_next.kind          = item.kind;
        stg_next.player        = item.player;
        stg_next.rem_cs        = prod[DIV10_SHIFT +: QCS_W];
        stg_next.time_left_sec = item.time_left_sec;
        stg_next.count_left    = item.count_left;
        valid_next             = item.ready ? item.valid : valid_reg;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_reg <= stg_next;
        end
    end

    assign stg_valid = valid_reg;
    assign stg       = stg_reg;

endmodule

/* rtl/byoclk_core.sv */
// ----------------------------------------------------------------------------
// byoclk_core
// Per-player clock state and its update for moves, set-time-left and
// reset items, followed by the result register of the reported clock.
// ----------------------------------------------------------------------------
module byoclk_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  byoclk_pkg::eff_cfg_t eff,
    input  logic                 stg_valid,
    input  byoclk_pkg::stage_t   stg,
    output logic                 advance,
    byoclk_result_if.source      result
);
    import byoclk_pkg::*;

    logic [CS_W-1:0]         main_left_reg  [2];
    logic signed [BYO_W-1:0] byo_left_reg   [2];
    logic [CNT_W-1:0]        periods_left_reg [2];
    logic [CNT_W-1:0]        stones_left_reg  [2];
    logic                    ot_reg         [2];

    logic [CS_W-1:0]         main_left_next [2];
    logic signed [BYO_W-1:0] byo_left_next  [2];
    logic [CNT_W-1:0]        periods_left_next [2];
    logic [CNT_W-1:0]        stones_left_next  [2];
    logic                    ot_next        [2];

    logic                    out_valid_reg;
    logic                    out_valid_next;
    report_t                 res_reg;
    report_t                 res_next;
    logic                    fire;

    // move arithmetic
    logic                    p;
    logic [CS_W-1:0]         m_cur;
    logic signed [BYO_W-1:0] b_cur;
    logic [CNT_W-1:0]        pr_cur;
    logic [CNT_W-1:0]        st_cur;
    logic                    ot_cur;
    logic [CS_W-1:0]         rem_ext;
    logic [CS_W-1:0]         m_mv;
    logic [CS_W-1:0]         r_mv;
    logic                    ot_mv;
    logic signed [BYO_W+1:0] b_sub;
    logic signed [BYO_W-1:0] b_mv;
    logic [CNT_W-1:0]        pr_mv;
    logic [CNT_W-1:0]        st_mv;
    logic                    move_skip;
    logic signed [BYO_W-1:0] eff_byo_s;

    // set-time-left arithmetic
    logic [SEC_W-1:0]        secs_sat;
    logic [CS_W-1:0]         secs_cs;

    assign advance   = !out_valid_reg || result.ready;
    assign fire      = stg_valid && advance;
    assign p         = stg.player;
    assign eff_byo_s = $signed({1'b0, eff.byo_cs});

    assign m_cur  = main_left_reg[p];
    assign b_cur  = byo_left_reg[p];
    assign pr_cur = periods_left_reg[p];
    assign st_cur = stones_left_reg[p];
    assign ot_cur = ot_reg[p];

    // charge main time, then overtime
    always_comb
    begin
        rem_ext   = CS_W'(stg.rem_cs);
        move_skip = eff.infinite || (m_cur == '0 && b_cur <= 0);
        m_mv      = m_cur;
        r_mv      = rem_ext;
        ot_mv     = ot_cur;
        b_mv      = b_cur;
        pr_mv     = pr_cur;
        st_mv     = st_cur;
        if (!ot_cur)
        begin
            if (m_cur >= rem_ext)
            begin
                m_mv = m_cur - rem_ext;
                r_mv = '0;
            end
            else
            begin
                r_mv  = rem_ext - m_cur;
                m_mv  = '0;
                ot_mv = 1'b1;
            end
        end
        b_sub = $signed({{2{b_cur[BYO_W-1]}}, b_cur}) - $signed({3'b000, r_mv});
        if (b_sub < $signed({{2{BYO_MIN[BYO_W-1]}}, BYO_MIN}))
        begin
            b_sub = $signed({{2{BYO_MIN[BYO_W-1]}}, BYO_MIN});
        end
        if (ot_mv && r_mv != '0)
        begin
            b_mv = b_sub[BYO_W-1:0];
            if (eff.periods != '0)
            begin
                // japanese periods
                if (b_mv < 0 && pr_cur != '0)
                begin
                    pr_mv = pr_cur - 1'b1;
                end
                if (pr_mv != '0)
                begin
                    b_mv = eff_byo_s;
                end
            end
            else if (eff.stones != '0)
            begin
                // canadian block
                if (st_cur != '0)
                begin
                    st_mv = st_cur - 1'b1;
                end
                if (st_mv == '0 && b_mv > 0)
                begin
                    b_mv  = eff_byo_s;
                    st_mv = eff.stones;
                end
            end
        end
    end

    // reported seconds to centiseconds
    always_comb
    begin
        secs_sat = (stg.time_left_sec > MAX_SEC_V) ? MAX_SEC_V : stg.time_left_sec;
        secs_cs  = CS_W'(secs_sat) * CS_W'(CS_PER_SEC);
    end

    // next clock state
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            main_left_next[i]    = main_left_reg[i];
            byo_left_next[i]     = byo_left_reg[i];
            periods_left_next[i] = periods_left_reg[i];
            stones_left_next[i]  = stones_left_reg[i];
            ot_next[i]           = ot_reg[i];
        end
        if (eff.refill || (fire && stg.kind == KIND_RESET))
        begin
            for (int i = 0; i < 2; i++)
            begin
                main_left_next[i]    = eff.main_cs;
                byo_left_next[i]     = eff_byo_s;
                periods_left_next[i] = eff.periods;
                stones_left_next[i]  = eff.stones;
                ot_next[i]           = (eff.main_cs == '0);
            end
        end
        else if (fire)
        begin
            case (stg.kind)
                KIND_MOVE:
                begin
                    if (!move_skip)
                    begin
                        main_left_next[p]    = m_mv;
                        byo_left_next[p]     = b_mv;
                        periods_left_next[p] = pr_mv;
                        stones_left_next[p]  = st_mv;
                        ot_next[p]           = ot_mv;
                    end
                end
                KIND_SET_LEFT:
                begin
                    if (secs_sat == '0 && stg.count_left == '0)
                    begin
                        byo_left_next[p]     = eff_byo_s;
                        stones_left_next[p]  = eff.stones;
                        periods_left_next[p] = eff.periods;
                    end
                    else if (stg.count_left == '0)
                    begin
                        main_left_next[p] = secs_cs;
                    end
                    else
                    begin
                        main_left_next[p] = '0;
                        byo_left_next[p]  = $signed({1'b0, secs_cs});
                        if (eff.periods != '0)
                        begin
                            periods_left_next[p] = stg.count_left;
                            stones_left_next[p]  = '0;
                        end
                        else if (eff.stones != '0)
                        begin
                            periods_left_next[p] = '0;
                            stones_left_next[p]  = stg.count_left;
                        end
                    end
                    for (int i = 0; i < 2; i++)
                    begin
                        ot_next[i] = (main_left_next[i] == '0);
                    end
                end
                default: ;
            endcase
        end
    end

    // report of the addressed player after the update
    always_comb
    begin
        res_next                   = res_reg;
        res_next.side              = p;
        res_next.main_left_cs      = main_left_next[p];
        res_next.byo_left_cs       = byo_left_next[p];
        res_next.periods_remaining = periods_left_next[p];
        res_next.stones_remaining  = stones_left_next[p];
        res_next.in_overtime       = ot_next[p];
        res_next.time_over         = (main_left_next[p] == '0) && (byo_left_next[p] <= 0);
        res_next.infinite_time     = eff.infinite;
        out_valid_next             = advance ? stg_valid : out_valid_reg;
    end

    // clock state, cleared to the all-zero settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                main_left_reg[i]    <= '0;
                byo_left_reg[i]     <= '0;
                periods_left_reg[i] <= '0;
                stones_left_reg[i]  <= '0;
                ot_reg[i]           <= 1'b1;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                main_left_reg[i]    <= main_left_next[i];
                byo_left_reg[i]     <= byo_left_next[i];
                periods_left_reg[i] <= periods_left_next[i];
                stones_left_reg[i]  <= stones_left_next[i];
                ot_reg[i]           <= ot_next[i];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.side              = res_reg.side;
    assign result.main_left_cs      = res_reg.main_left_cs;
    assign result.byo_left_cs       = res_reg.byo_left_cs;
    assign result.periods_remaining = res_reg.periods_remaining;
    assign result.stones_remaining  = res_reg.stones_remaining;
    assign result.in_overtime       = res_reg.in_overtime;
    assign result.time_over         = res_reg.time_over;
    assign result.infinite_time     = res_reg.infinite_time;

endmodule

/* rtl/byo_yomi_clock_accounting_top.sv */
// ----------------------------------------------------------------------------
// byo_yomi_clock_accounting_top
// Two-player game clock with main time and Japanese or Canadian byo-yomi.
// Path: the accepted item is registered in the divide stage, then the clock
// update is registered into the result register.
// Throughput: one item per cycle; a held result stalls only when both stages are full.
// Reset: settings cleared to zero (infinite time), both clocks empty with the
// overtime flag set; a register write sets the refill strobe register, which then refills both clocks.
// ----------------------------------------------------------------------------
module byo_yomi_clock_accounting_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    byoclk_item_if.sink     item,
    byoclk_result_if.source result
);
    import byoclk_pkg::*;

    eff_cfg_t eff;
    stage_t   stg;
    logic     stg_valid;
    logic     advance;

    // settings registers
    byoclk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff     (eff)
    );

    // input stage with ms to cs conversion
    byoclk_div10 u_div10 (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .advance   (advance),
        .stg_valid (stg_valid),
        .stg       (stg)
    );

    // clock state and result register
    byoclk_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff       (eff),
        .stg_valid (stg_valid),
        .stg       (stg),
        .advance   (advance),
        .result    (result)
    );

endmodule
